[rtl/core/otb_pkg.sv]
// Shared types and constants for the Otsu threshold binariser.
package otb_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR    = 2'd0,
		OP_ACCUM    = 2'd1,
		OP_COMPUTE  = 2'd2,
		OP_BINARIZE = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_CLR,
		S_ACC_RD,
		S_ACC_WR,
		S_SCAN,
		S_SCAN_TAIL,
		S_SCAN_DONE,
		S_EV_RD,
		S_EV_SQ1,
		S_EV_D1_GO,
		S_EV_D1_WAIT,
		S_EV_SQ2,
		S_EV_D2_GO,
		S_EV_D2_WAIT,
		S_EV_FIN,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic take;
		logic clr_wr;
		logic acc_rd;
		logic acc_wr;
		logic scan_rd;
		logic fin_scan;
		logic ev_init;
		logic sq_ld;
		logic sq_sel2;
		logic div_go;
		logic div_sel2;
		logic div1_cap;
		logic ev_step;
		logic fin_eval;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic ix_last;
		logic t_last;
		logic multi;
		logic div_done;
		logic out_free;
	} stat_t;

	localparam int SUM_W = 32;
	localparam int SQ_W = 64;
	localparam int PIX_W = 8;
	localparam int DIV_STEPS = 64;
	localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;

endpackage

[rtl/core/otsu_threshold_binarizer.sv]
// Top level of the Otsu threshold binariser.
//
// Input channel: in_valid/in_stall with opcode and pixel. Opcodes clear the
// histogram, accumulate a pixel, compute the threshold or binarise a pixel.
// Output channel: out_valid/out_stall with result_kind, out_pixel,
// threshold_value and histogram_empty; compute and binarise give one result.
// Clear sweeps every histogram bin, accumulate does one memory
// read-modify-write and binarise goes straight to the emit state. Compute
// scans the histogram for the lowest and highest occupied level, then
// scores each candidate split between them with the bit-serial divider,
// which runs twice per split, then emits the result.
// After reset the histogram memory is swept to zero, one bin per cycle,
// with in_stall high. The held threshold resets to zero.
// Results sit in an output register; while out_stall is high it holds, and
// clear or accumulate requests are still taken, while a new result waits
// in the emit state until the register frees.
module otsu_threshold_binarizer #(
	parameter int GREY_LEVELS = 256,
	parameter int COUNT_BITS  = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] opcode,
	input  logic [7:0] pixel,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       result_kind,
	output logic [7:0] out_pixel,
	output logic [7:0] threshold_value,
	output logic       histogram_empty
);
	import otb_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	otb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.stat     (stat),
		.cmd      (cmd)
	);

	otb_datapath #(
		.GREY_LEVELS (GREY_LEVELS),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.opcode          (opcode),
		.pixel           (pixel),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.result_kind     (result_kind),
		.out_pixel       (out_pixel),
		.threshold_value (threshold_value),
		.histogram_empty (histogram_empty)
	);

endmodule

[rtl/core/otb_div.sv]
// Restoring divider, one quotient bit per cycle.
module otb_div #(
	parameter int DW = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [63:0]            dividend,
	input  logic [DW-1:0]          divisor,
	output logic                   done,
	output logic [63:0]            quotient
);
	import otb_pkg::*;

	localparam int CW = $clog2(DIV_STEPS + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvsr_q;
	logic [63:0]   dvd_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          qbit;

	assign trial = {rem_q, dvd_q[63]};
	assign diff = trial - {1'b0, dvsr_q};
	assign qbit = (trial >= {1'b0, dvsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DW-1:0] : trial[DW-1:0];
			dvd_q <= {dvd_q[62:0], qbit};
		end
	end

	assign done = done_q;
	assign quotient = dvd_q;

endmodule

[rtl/core/otb_ctrl.sv]
// Sequencer for the Otsu threshold binariser.
module otb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [1:0]     opcode,
	input  otb_pkg::stat_t stat,
	output otb_pkg::cmd_t  cmd
);
	import otb_pkg::*;

	state_t state_q;
	state_t state_d;
	op_t    op;

	assign op = op_t'(opcode);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT, S_CLR: begin
				if (stat.ix_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					unique case (op)
						OP_CLEAR:    state_d = S_CLR;
						OP_ACCUM:    state_d = S_ACC_RD;
						OP_COMPUTE:  state_d = S_SCAN;
						OP_BINARIZE: state_d = S_EMIT;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_ACC_RD:    state_d = S_ACC_WR;
			S_ACC_WR:    state_d = S_IDLE;
			S_SCAN: begin
				if (stat.ix_last) state_d = S_SCAN_TAIL;
			end
			S_SCAN_TAIL: state_d = S_SCAN_DONE;
			S_SCAN_DONE: state_d = stat.multi ? S_EV_RD : S_EMIT;
			S_EV_RD:     state_d = S_EV_SQ1;
			S_EV_SQ1:    state_d = S_EV_D1_GO;
			S_EV_D1_GO:  state_d = S_EV_D1_WAIT;
			S_EV_D1_WAIT: begin
				if (stat.div_done) state_d = S_EV_SQ2;
			end
			S_EV_SQ2:    state_d = S_EV_D2_GO;
			S_EV_D2_GO:  state_d = S_EV_D2_WAIT;
			S_EV_D2_WAIT: begin
				if (stat.div_done) state_d = stat.t_last ? S_EV_FIN : S_EV_RD;
			end
			S_EV_FIN:    state_d = S_EMIT;
			S_EMIT: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default:     state_d = S_INIT;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_INIT, S_CLR: cmd.clr_wr = 1'b1;
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			S_ACC_RD:    cmd.acc_rd = 1'b1;
			S_ACC_WR:    cmd.acc_wr = 1'b1;
			S_SCAN:      cmd.scan_rd = 1'b1;
			S_SCAN_TAIL: ;
			S_SCAN_DONE: begin
				cmd.fin_scan = 1'b1;
				cmd.ev_init = stat.multi;
			end
			S_EV_RD:     ;
			S_EV_SQ1:    cmd.sq_ld = 1'b1;
			S_EV_D1_GO:  cmd.div_go = 1'b1;
			S_EV_D1_WAIT: cmd.div1_cap = stat.div_done;
			S_EV_SQ2: begin
				cmd.sq_ld = 1'b1;
				cmd.sq_sel2 = 1'b1;
			end
			S_EV_D2_GO: begin
				cmd.div_go = 1'b1;
				cmd.div_sel2 = 1'b1;
			end
			S_EV_D2_WAIT: cmd.ev_step = stat.div_done;
			S_EV_FIN:    cmd.fin_eval = 1'b1;
			S_EMIT:      cmd.emit = 1'b1;
			default:     ;
		endcase
	end

endmodule

[rtl/core/otb_datapath.sv]
// Histogram memory, totals, Otsu score evaluation and result register.
module otb_datapath #(
	parameter int GREY_LEVELS = 256,
	parameter int COUNT_BITS  = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	input  otb_pkg::cmd_t  cmd,
	output otb_pkg::stat_t stat,
	input  logic [1:0]     opcode,
	input  logic [7:0]     pixel,
	input  logic           out_stall,
	output logic           out_valid,
	output logic           result_kind,
	output logic [7:0]     out_pixel,
	output logic [7:0]     threshold_value,
	output logic           histogram_empty
);
	import otb_pkg::*;

	localparam int AW = $clog2(GREY_LEVELS);
	localparam int NW = COUNT_BITS + AW;
	localparam int SW = ((NW > SUM_W) ? NW : SUM_W) + 1;

	logic [COUNT_BITS-1:0] mem [GREY_LEVELS];
	logic [COUNT_BITS-1:0] rdata_q;

	logic [7:0]            px_q;
	logic                  is_bin_q;
	logic [AW-1:0]         ix_q, lo_q, hi_q, best_t_q, scan_ix_s1;
	logic                  scan_v_s1, found_q, first_q, empty_q, div_zero_q;
	logic [COUNT_BITS-1:0] total_q, cnt_q;
	logic [SUM_W-1:0]      sum_q, s1_q;
	logic [NW-1:0]         n1_q;
	logic [NW-1:0]         prod_q;
	logic [SQ_W-1:0]       sq_q, term1_q, best_q;
	logic [7:0]            held_q;
	logic                  out_valid_q, kind_q, empty_out_q;
	logic [7:0]            opix_q, thr_q;

	logic [AW+7:0]         px_ext, lo_ext, best_ext;
	logic [AW-1:0]         px_addr, rd_addr, wr_addr, hi_m1;
	logic                  in_range, mem_we, better, out_free;
	logic [COUNT_BITS-1:0] cnt_inc, tot_inc, wr_data;
	logic [SUM_W:0]        sum_add;
	logic [SUM_W-1:0]      sum_inc, s2, sq_op, s1_next;
	logic [NW-1:0]         tot_ext, n2, dvsr;
	logic [SQ_W-1:0]       sq_prod, quot, term, score;
	logic [SQ_W:0]         sc_add;
	logic [SW-1:0]         s1_add;
	logic                  div_done;

	assign px_ext = {{AW{1'b0}}, px_q};
	assign px_addr = px_ext[AW-1:0];
	assign lo_ext = {8'd0, lo_q};
	assign best_ext = {8'd0, best_t_q};
	assign in_range = (GREY_LEVELS > 255) || (32'(px_q) < 32'(GREY_LEVELS));
	assign rd_addr = cmd.acc_rd ? px_addr : ix_q;
	assign wr_addr = cmd.clr_wr ? ix_q : px_addr;
	assign cnt_inc = (rdata_q == '1) ? rdata_q : rdata_q + 1'b1;
	assign tot_inc = (total_q == '1) ? total_q : total_q + 1'b1;
	assign wr_data = cmd.clr_wr ? '0 : cnt_inc;
	assign mem_we = cmd.clr_wr || (cmd.acc_wr && in_range);
	assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(px_q);
	assign sum_inc = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

	assign tot_ext = NW'(total_q);
	assign n2 = (tot_ext > n1_q) ? tot_ext - n1_q : '0;
	assign s2 = (sum_q > s1_q) ? sum_q - s1_q : '0;
	assign sq_op = cmd.sq_sel2 ? s2 : s1_q;
	assign sq_prod = SQ_W'(sq_op) * SQ_W'(sq_op);
	assign dvsr = cmd.div_sel2 ? n2 : n1_q;
	assign term = div_zero_q ? '0 : quot;
	assign sc_add = {1'b0, term1_q} + {1'b0, term};
	assign score = sc_add[SQ_W] ? '1 : sc_add[SQ_W-1:0];
	assign better = first_q || (score > best_q);
	assign s1_add = SW'(s1_q) + SW'(prod_q);
	assign s1_next = (|s1_add[SW-1:SUM_W]) ? '1 : s1_add[SUM_W-1:0];
	assign hi_m1 = hi_q - 1'b1;
	assign out_free = !out_valid_q || !out_stall;

	assign stat.ix_last = (ix_q == AW'(GREY_LEVELS - 1));
	assign stat.t_last = (ix_q == hi_m1);
	assign stat.multi = found_q && (lo_q != hi_q);
	assign stat.div_done = div_done;
	assign stat.out_free = out_free;

	otb_div #(
		.DW(NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (sq_q),
		.divisor  (dvsr),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ix_q <= '0;
			total_q <= '0;
			sum_q <= '0;
			held_q <= '0;
			found_q <= 1'b0;
			scan_v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			scan_v_s1 <= cmd.scan_rd;
			if (cmd.take) begin
				ix_q <= '0;
				found_q <= 1'b0;
				if (op_t'(opcode) == OP_CLEAR) begin
					total_q <= '0;
					sum_q <= '0;
				end
			end else if (cmd.ev_init) begin
				ix_q <= lo_q;
			end else if (cmd.clr_wr || cmd.scan_rd || cmd.ev_step) begin
				ix_q <= ix_q + 1'b1;
			end
			if (cmd.acc_wr && in_range) begin
				total_q <= tot_inc;
				sum_q <= sum_inc;
			end
			if (scan_v_s1 && (rdata_q != '0)) found_q <= 1'b1;
			if (cmd.fin_scan) held_q <= found_q ? lo_ext[7:0] : 8'd0;
			if (cmd.fin_eval) held_q <= best_ext[7:0];
			if (cmd.emit && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			px_q <= pixel;
			is_bin_q <= (op_t'(opcode) == OP_BINARIZE);
		end
		if (cmd.scan_rd) scan_ix_s1 <= ix_q;
		if (scan_v_s1 && (rdata_q != '0)) begin
			if (!found_q) lo_q <= scan_ix_s1;
			hi_q <= scan_ix_s1;
		end
		if (cmd.fin_scan) empty_q <= !found_q;
		if (cmd.ev_init) begin
			n1_q <= '0;
			s1_q <= '0;
			first_q <= 1'b1;
		end
		if (cmd.sq_ld) sq_q <= sq_prod;
		if (cmd.sq_ld && !cmd.sq_sel2) begin
			cnt_q <= rdata_q;
			prod_q <= NW'(rdata_q) * NW'(ix_q);
		end
		if (cmd.div_go) div_zero_q <= (dvsr == '0);
		if (cmd.div1_cap) term1_q <= term;
		if (cmd.ev_step) begin
			if (better) begin
				best_q <= score;
				best_t_q <= ix_q;
			end
			first_q <= 1'b0;
			n1_q <= n1_q + NW'(cnt_q);
			s1_q <= s1_next;
		end
		if (cmd.emit && out_free) begin
			kind_q <= is_bin_q;
			opix_q <= (is_bin_q && (px_q > held_q)) ? PIX_WHITE : 8'd0;
			thr_q <= held_q;
			empty_out_q <= is_bin_q ? 1'b0 : empty_q;
		end
	end

	assign out_valid = out_valid_q;
	assign result_kind = kind_q;
	assign out_pixel = opix_q;
	assign threshold_value = thr_q;
	assign histogram_empty = empty_out_q;

endmodule

[rtl/core/otb_checker.sv]
// Port-level checks for the Otsu threshold binariser, bound to the top level.
module otb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] opcode,
	input logic       out_valid,
	input logic       out_stall,
	input logic       result_kind,
	input logic [7:0] out_pixel,
	input logic [7:0] threshold_value,
	input logic       histogram_empty
);
	import otb_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_pixel)
			&& $stable(threshold_value) && $stable(result_kind))
		else $error("stalled result changed");

	a_bin_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind |->
			(out_pixel == 8'd0 || out_pixel == 8'd255) && !histogram_empty)
		else $error("bad binarised result");

	a_thr_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !result_kind |-> out_pixel == 8'd0)
		else $error("threshold result carries a pixel");

	a_empty_thr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && histogram_empty |-> threshold_value == 8'd0)
		else $error("empty histogram with nonzero threshold");

	a_clr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode == OP_CLEAR |=> in_stall)
		else $error("request taken during clear sweep");

endmodule

bind otsu_threshold_binarizer otb_checker u_otb_checker (.*);

[tb/sv/tb_top.sv]
// Self-checking testbench for the Otsu threshold binariser, with a queued driver and a monitor.
module tb_top;
	import otb_pkg::*;

	typedef struct {
		op_t        op;
		logic [7:0] px;
	} request_t;

	typedef struct {
		logic       kind;
		logic [7:0] pix;
		logic [7:0] th;
		logic       empty;
	} verdict_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] opcode;
	logic [7:0] pixel;
	logic       out_valid;
	logic       out_stall;
	logic       result_kind;
	logic [7:0] out_pixel;
	logic [7:0] threshold_value;
	logic       histogram_empty;

	request_t pending_requests[$];
	verdict_t awaited_results[$];

	logic [23:0] bin_count[256];
	logic [23:0] pix_count;
	logic [31:0] level_sum;
	logic [7:0]  cur_threshold;

	int  errors;
	int  taken_results;
	int  send_gap;
	bit  send_burst;
	int  stall_left;
	int  hold_left;
	bit  hold_done;

	otsu_threshold_binarizer dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .pixel(pixel), .out_valid(out_valid), .out_stall(out_stall),
		.result_kind(result_kind), .out_pixel(out_pixel),
		.threshold_value(threshold_value), .histogram_empty(histogram_empty)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned split_term(longint unsigned s, longint unsigned n);
		if (n == 0)
			return 0;
		return (s * s) / n;
	endfunction

	task automatic otsu_pick(output logic [7:0] th, output logic empty);
		int lo, hi, t, best_t;
		bit found;
		longint unsigned n1, s1, n2, s2, a, b, score, best;
		lo = 0; hi = 0; found = 0; n1 = 0; s1 = 0; best = 0; best_t = 0;
		for (int i = 0; i < 256; i++) begin
			if (bin_count[i] != 0) begin
				if (!found)
					lo = i;
				hi = i;
				found = 1;
			end
		end
		empty = !found;
		if (!found) begin
			th = 8'd0;
			return;
		end
		best_t = lo;
		for (t = lo; t < hi; t++) begin
			n2 = (pix_count > n1) ? pix_count - n1 : 0;
			s2 = (level_sum > s1) ? level_sum - s1 : 0;
			a = split_term(s1, n1);
			b = split_term(s2, n2);
			score = a + b;
			if (score < a)
				score = '1;
			if (t == lo || score > best) begin
				best = score;
				best_t = t;
			end
			n1 += bin_count[t];
			s1 += longint'(bin_count[t]) * t;
			if (s1 > 64'hFFFF_FFFF)
				s1 = 64'hFFFF_FFFF;
		end
		th = best_t[7:0];
	endtask

	task automatic apply_request(op_t op, logic [7:0] px);
		verdict_t v;
		case (op)
			OP_CLEAR: begin
				foreach (bin_count[i]) bin_count[i] = '0;
				pix_count = '0;
				level_sum = '0;
			end
			OP_ACCUM: begin
				if (bin_count[px] != '1) bin_count[px]++;
				if (pix_count != '1) pix_count++;
				if (level_sum > 32'hFFFF_FFFF - px)
					level_sum = '1;
				else
					level_sum += px;
			end
			OP_COMPUTE: begin
				otsu_pick(cur_threshold, v.empty);
				v.kind = 1'b0;
				v.pix = 8'd0;
				v.th = cur_threshold;
				awaited_results.push_back(v);
			end
			default: begin
				v.kind = 1'b1;
				v.pix = (px > cur_threshold) ? PIX_WHITE : 8'd0;
				v.th = cur_threshold;
				v.empty = 1'b0;
				awaited_results.push_back(v);
			end
		endcase
	endtask

	task automatic queue_request(op_t op, logic [7:0] px);
		request_t r;
		r.op = op;
		r.px = px;
		pending_requests.push_back(r);
	endtask

	initial begin
		int n, base, span, p;
		foreach (bin_count[i]) bin_count[i] = '0;
		pix_count = '0;
		level_sum = '0;
		cur_threshold = '0;
		// directed: empty image, full-range image, single level, every pixel bit
		queue_request(OP_BINARIZE, 8'd0);
		queue_request(OP_BINARIZE, 8'd1);
		queue_request(OP_COMPUTE, 8'd0);
		queue_request(OP_ACCUM, 8'd0);
		queue_request(OP_ACCUM, 8'd255);
		queue_request(OP_ACCUM, 8'd255);
		queue_request(OP_COMPUTE, 8'd0);
		queue_request(OP_BINARIZE, 8'd255);
		queue_request(OP_BINARIZE, 8'd0);
		queue_request(OP_CLEAR, 8'd0);
		queue_request(OP_ACCUM, 8'd77);
		queue_request(OP_ACCUM, 8'd77);
		queue_request(OP_COMPUTE, 8'd0);
		queue_request(OP_BINARIZE, 8'd77);
		queue_request(OP_BINARIZE, 8'd78);
		queue_request(OP_CLEAR, 8'd0);
		queue_request(OP_ACCUM, 8'h55);
		queue_request(OP_ACCUM, 8'h5A);
		queue_request(OP_ACCUM, 8'h50);
		queue_request(OP_ACCUM, 8'h5F);
		queue_request(OP_COMPUTE, 8'd0);
		queue_request(OP_BINARIZE, 8'hAA);
		queue_request(OP_CLEAR, 8'd0);
		queue_request(OP_COMPUTE, 8'd0);
		queue_request(OP_BINARIZE, 8'h80);
		while (pending_requests.size() < 600) begin
			if ($urandom_range(0, 6) == 0) begin
				p = $urandom_range(0, 255);
				n = $urandom_range(0, 3);
				if (n == OP_COMPUTE && $urandom_range(0, 2) != 0)
					n = OP_BINARIZE;
				queue_request(op_t'(n), p[7:0]);
			end else begin
				if ($urandom_range(0, 4) != 0)
					queue_request(OP_CLEAR, 8'($urandom));
				base = $urandom_range(0, 255);
				span = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 7);
				n = $urandom_range(1, 12);
				repeat (n) begin
					p = base + $urandom_range(0, span);
					if (p > 255) p = 255;
					queue_request(OP_ACCUM, p[7:0]);
				end
				queue_request(OP_COMPUTE, 8'($urandom));
				n = $urandom_range(1, 6);
				repeat (n) begin
					p = ($urandom_range(0, 1) != 0) ? base + $urandom_range(0, span) - 1
						: $urandom_range(0, 255);
					if (p < 0) p = 0;
					if (p > 255) p = 255;
					queue_request(OP_BINARIZE, p[7:0]);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk or negedge arst_n) begin
		request_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= OP_CLEAR;
			pixel <= 8'd0;
			send_gap = 0;
			send_burst = 0;
		end else begin
			if (in_valid && !in_stall)
				apply_request(op_t'(opcode), pixel);
			if (!(in_valid && in_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					r = pending_requests.pop_front();
					in_valid <= 1'b1;
					opcode <= r.op;
					pixel <= r.px;
					if ($urandom_range(0, 15) == 0)
						send_burst = !send_burst;
					send_gap = send_burst ? 0 : $urandom_range(0, 7);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		verdict_t v;
		bit hold;
		if (!arst_n) begin
			out_stall <= 1'b0;
			taken_results = 0;
			stall_left = 0;
			hold_left = 0;
			hold_done = 0;
			errors = 0;
		end else begin
			if (out_valid && !out_stall) begin
				taken_results++;
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result kind %0b pix %0d th %0d empty %0b",
						$time, result_kind, out_pixel, threshold_value, histogram_empty);
					errors++;
				end else begin
					v = awaited_results.pop_front();
					if (result_kind !== v.kind || out_pixel !== v.pix ||
						threshold_value !== v.th || histogram_empty !== v.empty) begin
						$display("%0t: expected kind %0b pix %0d th %0d empty %0b, got %0b %0d %0d %0b",
							$time, v.kind, v.pix, v.th, v.empty,
							result_kind, out_pixel, threshold_value, histogram_empty);
						errors++;
					end
				end
				stall_left = (send_burst) ? 0 : $urandom_range(0, 7);
			end
			if (!hold_done && taken_results >= 60) begin
				hold_done = 1;
				hold_left = 400;
			end
			hold = 0;
			if (hold_left > 0) begin
				hold_left--;
				hold = 1;
			end else if (stall_left > 0) begin
				stall_left--;
				hold = 1;
			end
			out_stall <= hold;
		end
	end

	initial begin
		do @(posedge clk);
		while (!arst_n || pending_requests.size() > 0 || in_valid || awaited_results.size() > 0);
		repeat (400) @(posedge clk);
		if (awaited_results.size() > 0) begin
			$display("%0t: %0d results never arrived", $time, awaited_results.size());
			errors++;
		end
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#400_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

[files.f]
rtl/core/otb_pkg.sv
rtl/core/otb_div.sv
rtl/core/otb_ctrl.sv
rtl/core/otb_datapath.sv
rtl/core/otsu_threshold_binarizer.sv
rtl/core/otb_checker.sv
tb/sv/tb_top.sv
